@@ sv/packed_alpha_glyph_unpacker_top_assert.svh @@
// Assertion macros for the packed alpha glyph unpacker.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef PACKED_ALPHA_GLYPH_UNPACKER_TOP_ASSERT_SVH
`define PACKED_ALPHA_GLYPH_UNPACKER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Check prop at every rising clock edge, ignored while reset is asserted.
`define PAGU_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("pagu assertion failed");
// Same check, also active during reset.
`define PAGU_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("pagu assertion failed");
`else
`define PAGU_ASSERT(label, clk, rst_n, prop)
`define PAGU_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

@@ sv/pagu_pkg.sv @@
// Shared types and constants for the packed alpha glyph unpacker.
// No dependencies.
`default_nettype none

package pagu_pkg;

    localparam int MAX_GLYPH_DIM = 256;
    localparam int DIM_CAP       = (MAX_GLYPH_DIM < 256) ? MAX_GLYPH_DIM : 256;

    localparam int DIM_W   = 9;     // width of size registers
    localparam int POS_W   = 8;     // width of column / line
    localparam int ALPHA_W = 8;
    localparam int BYTE_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    typedef logic [DIM_W-1:0]   t_dim;
    typedef logic [POS_W-1:0]   t_pos;
    typedef logic [ALPHA_W-1:0] t_alpha;
    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_dim DIM_CAP_V = t_dim'(DIM_CAP);

    // register indexes
    localparam t_cfg_idx REG_BPP_MODE     = 2'd0;
    localparam t_cfg_idx REG_GLYPH_WIDTH  = 2'd1;
    localparam t_cfg_idx REG_GLYPH_HEIGHT = 2'd2;

    // bpp_mode codes
    localparam logic [1:0] BPP_1   = 2'd0;
    localparam logic [1:0] BPP_2   = 2'd1;
    localparam logic [1:0] BPP_4   = 2'd2;
    localparam logic [1:0] BPP_4_ALT = 2'd3;

    localparam logic [1:0] BPP_MODE_RST = BPP_4;

endpackage

`default_nettype wire

@@ sv/pagu_in_if.sv @@
// Input channel: one packed bitmap byte per item, valid/ready handshake.
// Depends on pagu_pkg.
`default_nettype none

interface pagu_in_if;
    logic            valid;
    logic            ready;
    pagu_pkg::t_byte packed_byte;

    modport source (output valid, output packed_byte, input ready);
    modport sink   (input valid, input packed_byte, output ready);
endinterface

`default_nettype wire

@@ sv/pagu_out_if.sv @@
// Output channel: one alpha pixel with coordinates and marks per item.
// Depends on pagu_pkg.
`default_nettype none

interface pagu_out_if;
    logic             valid;
    logic             ready;
    pagu_pkg::t_alpha alpha;
    pagu_pkg::t_pos   column;
    pagu_pkg::t_pos   line;
    logic             row_end;
    logic             glyph_end;
    logic             run_last;

    modport source (output valid, output alpha, output column, output line,
                    output row_end, output glyph_end, output run_last, input ready);
    modport sink   (input valid, input alpha, input column, input line,
                    input row_end, input glyph_end, input run_last, output ready);
endinterface

`default_nettype wire

@@ sv/packed_alpha_glyph_unpacker_top.sv @@
// Packed alpha glyph unpacker: a byte waits in r_byte, pixels in the output register.
// Throughput: one pixel per cycle while o_out is ready; a byte gives 8, 4 or 2 pixels
// at 1, 2 or 4 bpp (fewer when the glyph ends inside it), set by the single pixel
// emitter stage. A new byte is taken in the cycle its predecessor's last pixel leaves
// the emitter. Reset (synchronous, i_rst_n low): position to origin, pipeline empty,
// bpp_mode = 4 bpp, glyph_width = glyph_height = 1.
`default_nettype none
`include "packed_alpha_glyph_unpacker_top_assert.svh"

module packed_alpha_glyph_unpacker_top (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  pagu_pkg::t_cfg_idx    i_cfg_idx,
    input  pagu_pkg::t_cfg_data   i_cfg_wdata,
    pagu_in_if.sink               i_in,
    pagu_out_if.source            o_out
);
    import pagu_pkg::*;

    // ---------------- configuration registers ----------------
    logic [1:0] r_bpp_mode;
    t_dim       r_glyph_width;
    t_dim       r_glyph_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp_mode     <= BPP_MODE_RST;
            r_glyph_width  <= t_dim'(1);
            r_glyph_height <= t_dim'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BPP_MODE:     r_bpp_mode     <= i_cfg_wdata[1:0];
                REG_GLYPH_WIDTH:  r_glyph_width  <= i_cfg_wdata;
                REG_GLYPH_HEIGHT: r_glyph_height <= i_cfg_wdata;
                default: ;        // unused index: write ignored
            endcase
        end
    end

    // Effective box size: zero reads as one, oversize saturates.
    t_dim w_eff;
    t_dim h_eff;

    always_comb begin
        if (r_glyph_width == '0) begin
            w_eff = t_dim'(1);
        end else if (r_glyph_width > DIM_CAP_V) begin
            w_eff = DIM_CAP_V;
        end else begin
            w_eff = r_glyph_width;
        end
        if (r_glyph_height == '0) begin
            h_eff = t_dim'(1);
        end else if (r_glyph_height > DIM_CAP_V) begin
            h_eff = DIM_CAP_V;
        end else begin
            h_eff = r_glyph_height;
        end
    end

    // ---------------- input stage ----------------
    // r_byte shifts left as pixels leave, so the current pixel is always
    // in its top bits. r_slot counts pixels taken from this byte.
    t_byte      r_byte;
    logic [2:0] r_slot;
    logic       r_busy;

    // ---------------- position ----------------
    t_pos r_col;
    t_pos r_row;

    // ---------------- output register ----------------
    logic   r_ovalid;
    t_alpha r_alpha;
    t_pos   r_ocol;
    t_pos   r_oline;
    logic   r_orow_end;
    logic   r_oglyph_end;
    logic   r_orun_last;

    // pixel decode for current mode
    logic [2:0] last_slot;
    t_alpha     pix_alpha;
    t_byte      shifted_byte;

    always_comb begin
        unique case (r_bpp_mode)
            BPP_1: begin
                last_slot    = 3'd7;
                pix_alpha    = {8{r_byte[7]}};
                shifted_byte = {r_byte[6:0], 1'b0};
            end
            BPP_2: begin
                last_slot    = 3'd3;         // value * 85 = value repeated
                pix_alpha    = {4{r_byte[7:6]}};
                shifted_byte = {r_byte[5:0], 2'b00};
            end
            BPP_4, BPP_4_ALT: begin
                last_slot    = 3'd1;         // value * 17 = nibble repeated
                pix_alpha    = {2{r_byte[7:4]}};
                shifted_byte = {r_byte[3:0], 4'b0000};
            end
            default: begin
                last_slot    = 3'd1;
                pix_alpha    = {2{r_byte[7:4]}};
                shifted_byte = {r_byte[3:0], 4'b0000};
            end
        endcase
    end

    logic pix_rend;
    logic pix_gend;
    logic pix_last;
    logic emit;
    logic in_take;

    assign pix_rend = ({1'b0, r_col} + t_dim'(1)) >= w_eff;
    assign pix_gend = pix_rend && (({1'b0, r_row} + t_dim'(1)) >= h_eff);
    assign pix_last = pix_gend || (r_slot == last_slot);

    // The emitter fires when it holds a byte and the output register is free
    // or being drained this cycle.
    assign emit    = r_busy && (!r_ovalid || o_out.ready);
    assign i_in.ready = !r_busy || (emit && pix_last);
    assign in_take = i_in.valid && i_in.ready;

    // control: busy, slot, position, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_slot   <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (in_take) begin
                r_busy <= 1'b1;
                r_slot <= '0;
            end else if (emit) begin
                r_busy <= !pix_last;
                r_slot <= r_slot + 3'd1;
            end

            if (emit) begin
                if (pix_gend) begin
                    r_col <= '0;
                    r_row <= '0;
                end else if (pix_rend) begin
                    r_col <= '0;
                    r_row <= r_row + t_pos'(1);
                end else begin
                    r_col <= r_col + t_pos'(1);
                end
            end

            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_byte <= i_in.packed_byte;
        end else if (emit) begin
            r_byte <= shifted_byte;
        end
        if (emit) begin
            r_alpha      <= pix_alpha;
            r_ocol       <= r_col;
            r_oline      <= r_row;
            r_orow_end   <= pix_rend;
            r_oglyph_end <= pix_gend;
            r_orun_last  <= pix_last;
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.alpha     = r_alpha;
    assign o_out.column    = r_ocol;
    assign o_out.line      = r_oline;
    assign o_out.row_end   = r_orow_end;
    assign o_out.glyph_end = r_oglyph_end;
    assign o_out.run_last  = r_orun_last;

    // ---------------- checks ----------------
    `PAGU_ASSERT(a_slot_in_range, i_clk, i_rst_n, r_busy |-> (r_slot <= last_slot))
    `PAGU_ASSERT(a_gend_is_last, i_clk, i_rst_n,
                 (r_ovalid && r_oglyph_end) |-> (r_orun_last && r_orow_end))
    `PAGU_ASSERT(a_gend_origin, i_clk, i_rst_n,
                 (emit && pix_gend) |=> (r_col == '0 && r_row == '0))
    `PAGU_ASSERT(a_no_take_midbyte, i_clk, i_rst_n,
                 (in_take && r_busy) |-> (emit && pix_last))

endmodule

`default_nettype wire
